// ===== hdl/mwas_pkg.sv =====
// Shared types, constants and codes of the max-weight assignment solver.
`default_nettype none
package mwas_pkg;

  localparam int unsigned MaxSide = 16;
  localparam int unsigned SideN   = MaxSide + 1;
  localparam int unsigned IdxW    = $clog2(SideN);
  localparam int unsigned VtxW    = $clog2(MaxSide);
  localparam int unsigned AddrW   = 2 * VtxW;
  localparam int unsigned WgtW    = 31;
  localparam int unsigned PotW    = 40;
  localparam int unsigned TotW    = 35;

  localparam logic signed [PotW-1:0] SlackInf = {1'b0, {(PotW-1){1'b1}}};

  localparam logic OpAdd   = 1'b0;
  localparam logic OpSolve = 1'b1;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusLeftOor  = 2'd1;
  localparam logic [1:0] StatusRightOor = 2'd2;

  localparam logic [1:0] RegLeftCount  = 2'd0;
  localparam logic [1:0] RegRightCount = 2'd1;

  typedef struct packed {
    logic               opcode;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [31:0] edge_weight;
  } mwas_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [VtxW-1:0] left_vertex;
    logic [VtxW-1:0] right_vertex;
    logic [TotW-1:0] total_weight;
    logic            last;
  } mwas_result_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [WgtW-1:0]  wdata;
    logic [AddrW-1:0] raddr;
  } mwas_mem_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_INIT,
    ST_RMAX_RD,
    ST_RMAX_EV,
    ST_PH_START,
    ST_PH_ROW,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SCAN_CMP,
    ST_CHECK,
    ST_UPD,
    ST_AUG,
    ST_EMIT_RD,
    ST_EMIT_EV,
    ST_FINAL
  } mwas_state_e;

endpackage
`default_nettype wire

// ===== hdl/mwas_wmem.sv =====
// Weight matrix RAM with per-entry valid bits; invalid entries read as zero.
`default_nettype none
module mwas_wmem
  import mwas_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clr_i,
  input  wire mwas_mem_req_t req_i,
  output logic [WgtW-1:0]    rdata_o
);

  localparam int unsigned Depth = 2 ** AddrW;

  logic [WgtW-1:0]  mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [WgtW-1:0]  rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[req_i.raddr];
      if (clr_i) begin
        vld_q <= '0;
      end else if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule
`default_nettype wire

// ===== hdl/mwas_core.sv =====
// Sequencer and shared datapath of the Hungarian assignment solver.
`default_nettype none
module mwas_core
  import mwas_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire mwas_item_t    item_i,
  input  wire logic [IdxW-1:0] lc_i,
  input  wire logic [IdxW-1:0] rc_i,
  input  wire logic [WgtW-1:0] rdata_i,
  output mwas_mem_req_t      req_o,
  output logic               busy,
  output logic               res_valid_o,
  output mwas_result_t       res_o
);

  mwas_state_e state_q, state_d;

  logic [IdxW-1:0] i_q, j_q, j0_q, j1_q, i0_q;
  logic signed [PotW-1:0] rp_i0_q, delta_q, cur_q;
  logic [WgtW-1:0] m_q, w_q;
  logic [TotW-1:0] total_q;
  logic [VtxW-1:0] r_q, c_q;
  logic [1:0]      st_q;

  logic [IdxW-1:0]        owner_q [SideN];
  logic signed [PotW-1:0] rp_q    [SideN];
  logic signed [PotW-1:0] cp_q    [SideN];
  logic signed [PotW-1:0] ms_q    [SideN];
  logic [IdxW-1:0]        bl_q    [SideN];
  logic [SideN-1:0]       used_q;

  logic [IdxW-1:0] n;
  logic [IdxW-1:0] u;
  logic            emit_ok;
  logic [1:0]      st_new;
  logic [IdxW-1:0] row_m1, col_m1;
  logic signed [PotW-1:0] ms_new;
  logic            cur_lt;

  assign n       = (lc_i > rc_i) ? lc_i : rc_i;
  assign u       = owner_q[j_q];
  assign emit_ok = (u != '0) && (u <= lc_i) && (j_q <= rc_i);
  assign cur_lt  = cur_q < ms_q[j_q];
  assign ms_new  = cur_lt ? cur_q : ms_q[j_q];

  always_comb begin
    priority if ({1'b0, item_i.row_index} >= {2'b0, lc_i}) begin
      st_new = StatusLeftOor;
    end else if ({1'b0, item_i.col_index} >= {2'b0, rc_i}) begin
      st_new = StatusRightOor;
    end else begin
      st_new = StatusOk;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (start) state_d = (item_i.opcode == OpSolve) ? ST_INIT : ST_ADD_RD;
      ST_ADD_RD:   state_d = ST_ADD_WR;
      ST_ADD_WR:   state_d = ST_IDLE;
      ST_INIT:     state_d = ST_RMAX_RD;
      ST_RMAX_RD: begin
        if (i_q > n) state_d = ST_PH_START;
        else if (j_q <= n) state_d = ST_RMAX_EV;
      end
      ST_RMAX_EV:  state_d = ST_RMAX_RD;
      ST_PH_START: state_d = (i_q > n) ? ST_EMIT_RD : ST_PH_ROW;
      ST_PH_ROW:   state_d = ST_SCAN_RD;
      ST_SCAN_RD: begin
        if (j_q > n) state_d = ST_CHECK;
        else if (!used_q[j_q]) state_d = ST_SCAN_EV;
      end
      ST_SCAN_EV:  state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: state_d = ST_SCAN_RD;
      ST_CHECK:    state_d = (j1_q == '0) ? ST_AUG : ST_UPD;
      ST_UPD: begin
        if (j_q > n) state_d = (owner_q[j1_q] != '0) ? ST_PH_ROW : ST_AUG;
      end
      ST_AUG:      if (j0_q == '0) state_d = ST_PH_START;
      ST_EMIT_RD: begin
        if (j_q > n) state_d = ST_FINAL;
        else if (emit_ok) state_d = ST_EMIT_EV;
      end
      ST_EMIT_EV:  state_d = ST_EMIT_RD;
      ST_FINAL:    state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // memory requests and results
  always_comb begin
    row_m1      = '0;
    col_m1      = '0;
    req_o       = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (state_q)
      ST_RMAX_RD: begin
        row_m1 = i_q - 1'b1;
        col_m1 = j_q - 1'b1;
      end
      ST_SCAN_RD: begin
        row_m1 = i0_q - 1'b1;
        col_m1 = j_q - 1'b1;
      end
      ST_EMIT_RD, ST_EMIT_EV: begin
        row_m1 = u - 1'b1;
        col_m1 = j_q - 1'b1;
      end
      default: begin
        row_m1 = '0;
        col_m1 = '0;
      end
    endcase
    req_o.raddr = (state_q == ST_ADD_RD) ? {r_q, c_q} : {row_m1[VtxW-1:0], col_m1[VtxW-1:0]};
    req_o.waddr = {r_q, c_q};
    req_o.wdata = w_q;
    unique case (state_q)
      ST_ADD_WR: begin
        req_o.we     = (st_q == StatusOk) && (w_q > rdata_i);
        res_valid_o  = 1'b1;
        res_o.status = st_q;
        res_o.last   = 1'b1;
      end
      ST_EMIT_EV: begin
        res_valid_o        = rdata_i != '0;
        res_o.left_vertex  = row_m1[VtxW-1:0];
        res_o.right_vertex = col_m1[VtxW-1:0];
      end
      ST_FINAL: begin
        res_valid_o        = 1'b1;
        res_o.total_weight = total_q;
        res_o.last         = 1'b1;
      end
      default: res_valid_o = 1'b0;
    endcase
  end

  assign busy = state_q != ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      j0_q    <= '0;
      j1_q    <= '0;
      i0_q    <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_INIT: begin
          i_q <= IdxW'(1);
          j_q <= IdxW'(1);
        end
        ST_RMAX_RD: begin
          if (i_q > n) begin
            i_q <= IdxW'(1);
          end else if (j_q > n) begin
            i_q <= i_q + 1'b1;
            j_q <= IdxW'(1);
          end
        end
        ST_RMAX_EV: j_q <= j_q + 1'b1;
        ST_PH_START: begin
          j0_q <= '0;
          j_q  <= IdxW'(1);
        end
        ST_PH_ROW: begin
          i0_q <= owner_q[j0_q];
          j1_q <= '0;
          j_q  <= IdxW'(1);
        end
        ST_SCAN_RD: if (j_q <= n && used_q[j_q]) j_q <= j_q + 1'b1;
        ST_SCAN_CMP: begin
          if (ms_new < delta_q) j1_q <= j_q;
          j_q <= j_q + 1'b1;
        end
        ST_CHECK: j_q <= '0;
        ST_UPD: begin
          if (j_q > n) j0_q <= j1_q;
          else j_q <= j_q + 1'b1;
        end
        ST_AUG: begin
          if (j0_q == '0) begin
            i_q <= i_q + 1'b1;
          end else begin
            j0_q <= (bl_q[j0_q] > IdxW'(MaxSide)) ? '0 : bl_q[j0_q];
          end
        end
        ST_EMIT_RD: if (j_q <= n && !emit_ok) j_q <= j_q + 1'b1;
        ST_EMIT_EV: j_q <= j_q + 1'b1;
        default: i_q <= i_q;
      endcase
    end
  end

  // datapath and working arrays
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        r_q  <= item_i.row_index[VtxW-1:0];
        c_q  <= item_i.col_index[VtxW-1:0];
        w_q  <= item_i.edge_weight[31] ? '0 : item_i.edge_weight[WgtW-1:0];
        st_q <= st_new;
      end
      ST_INIT: begin
        for (int k = 0; k < SideN; k++) begin
          owner_q[k] <= '0;
          cp_q[k]    <= '0;
          bl_q[k]    <= '0;
        end
        rp_q[0] <= '0;
        m_q     <= '0;
        total_q <= '0;
      end
      ST_RMAX_RD: begin
        if (i_q <= n && j_q > n) begin
          rp_q[i_q] <= $signed({{(PotW-WgtW){1'b0}}, m_q});
          m_q       <= '0;
        end
      end
      ST_RMAX_EV: if (rdata_i > m_q) m_q <= rdata_i;
      ST_PH_START: begin
        if (i_q <= n) owner_q[0] <= i_q;
        for (int k = 0; k < SideN; k++) ms_q[k] <= SlackInf;
        used_q <= '0;
      end
      ST_PH_ROW: begin
        used_q[j0_q] <= 1'b1;
        delta_q      <= SlackInf;
        rp_i0_q      <= rp_q[owner_q[j0_q]];
      end
      ST_SCAN_EV: cur_q <= rp_i0_q + cp_q[j_q] - $signed({{(PotW-WgtW){1'b0}}, rdata_i});
      ST_SCAN_CMP: begin
        if (cur_lt) begin
          ms_q[j_q] <= cur_q;
          bl_q[j_q] <= j0_q;
        end
        if (ms_new < delta_q) delta_q <= ms_new;
      end
      ST_UPD: begin
        if (j_q <= n) begin
          if (used_q[j_q]) begin
            rp_q[owner_q[j_q]] <= rp_q[owner_q[j_q]] - delta_q;
            cp_q[j_q]          <= cp_q[j_q] + delta_q;
          end else begin
            ms_q[j_q] <= ms_q[j_q] - delta_q;
          end
        end
      end
      ST_AUG: begin
        if (j0_q != '0) begin
          owner_q[j0_q] <= (bl_q[j0_q] > IdxW'(MaxSide)) ? owner_q[0] : owner_q[bl_q[j0_q]];
        end
      end
      ST_EMIT_EV: total_q <= total_q + TotW'(rdata_i);
      default: m_q <= m_q;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/max_weight_assignment_solver_top.sv =====
// Top level of the max-weight assignment solver: config registers, RAM and core.
// Add-edge item: RAM read in ST_ADD_RD, result strobe in ST_ADD_WR; busy meanwhile.
// Solve item: row maxima first, then per augment step a scan through ST_SCAN_RD,
//   ST_SCAN_EV and ST_SCAN_CMP for each free column plus an update pass, all paced
//   by the one shared slack unit and the single read port of the weight RAM; then emit.
// Results cannot be stalled; one strobe per cycle at most, the last one marked.
// Reset clears control state, sets both counts to 16 and invalidates all weights.
`default_nettype none
module max_weight_assignment_solver_top
  import mwas_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire mwas_item_t item_i,
  output logic            busy,
  output logic            res_valid_o,
  output mwas_result_t    res_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [4:0] cfg_data_i
);

  logic [4:0]      lc_q, rc_q;
  logic [IdxW-1:0] lc_eff, rc_eff;
  logic            cfg_wr;
  logic            clr;
  mwas_mem_req_t   req;
  logic [WgtW-1:0] rdata;

  // Accept config only while idle and no item is starting; any count write
  // starts a fresh problem.
  assign cfg_ready_o = !busy && !start;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign clr         = cfg_wr && (cfg_index_i == RegLeftCount || cfg_index_i == RegRightCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q <= 5'(MaxSide);
      rc_q <= 5'(MaxSide);
    end else if (cfg_wr) begin
      if (cfg_index_i == RegLeftCount)  lc_q <= cfg_data_i;
      if (cfg_index_i == RegRightCount) rc_q <= cfg_data_i;
    end
  end

  // Saturate counts at the matrix side.
  assign lc_eff = (lc_q > 5'(MaxSide)) ? IdxW'(MaxSide) : IdxW'(lc_q);
  assign rc_eff = (rc_q > 5'(MaxSide)) ? IdxW'(MaxSide) : IdxW'(rc_q);

  mwas_wmem u_wmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (clr),
    .req_i   (req),
    .rdata_o (rdata)
  );

  mwas_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .item_i      (item_i),
    .lc_i        (lc_eff),
    .rc_i        (rc_eff),
    .rdata_i     (rdata),
    .req_o       (req),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // A result transaction only occurs while an item is in flight.
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy) else $error("result outside busy");

  // An accepted item keeps the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item dropped");

  // The last result closes the item.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> !busy) else $error("busy after last result");

endmodule
`default_nettype wire

// ===== verif/max_weight_assignment_solver_checker.sv =====
// Checker for the max-weight assignment solver: watches all channels, predicts, compares.
`timescale 1ns / 100ps
module max_weight_assignment_solver_checker
  import mwas_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         busy_i,
  input  mwas_item_t   item_i,
  input  logic         res_valid_i,
  input  mwas_result_t res_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [4:0]   cfg_data_i,
  output int           errors_o,
  output int           pending_o
);

  localparam longint SlackMax = 64'sh7fff_ffff_ffff_ffff;

  logic [WgtW-1:0] weights [MaxSide][MaxSide];
  logic [4:0]      left_cnt;
  logic [4:0]      right_cnt;
  int              col_owner [SideN];
  longint          row_pot   [SideN];
  longint          col_pot   [SideN];
  longint          slack     [SideN];
  int              back      [SideN];
  bit              col_seen  [SideN];
  mwas_result_t    expected_results [$];
  int              errors;

  assign errors_o  = errors;
  assign pending_o = expected_results.size();

  function automatic int clamp_count(logic [4:0] c);
    return (c > MaxSide) ? MaxSide : int'(c);
  endfunction

  // 1-based weight lookup, zero outside storage
  function automatic longint weight_at(int r, int c);
    if (r < 1 || c < 1 || r > MaxSide || c > MaxSide) return 0;
    return longint'(weights[r-1][c-1]);
  endfunction

  function automatic mwas_result_t make_result(logic [1:0] st, int l, int r,
                                               logic [TotW-1:0] tot, logic lst);
    mwas_result_t res;
    res.status       = st;
    res.left_vertex  = l[VtxW-1:0];
    res.right_vertex = r[VtxW-1:0];
    res.total_weight = tot;
    res.last         = lst;
    return res;
  endfunction

  task automatic queue_expected(mwas_result_t res);
    expected_results.insert(expected_results.size(), res);
  endtask

  task automatic clear_weights();
    foreach (weights[r, c]) weights[r][c] = '0;
  endtask

  // Shortest augmenting path per row, potentials on rows and columns.
  task automatic run_assignment(int n);
    int     j0, j1, i0;
    longint m, cur, delta;
    for (int j = 0; j < SideN; j++) begin
      col_owner[j] = 0;
      col_pot[j]   = 0;
      back[j]      = 0;
    end
    row_pot[0] = 0;
    for (int i = 1; i <= n; i++) begin
      m = 0;
      for (int j = 1; j <= n; j++)
        if (weight_at(i, j) > m) m = weight_at(i, j);
      row_pot[i] = m;
    end
    for (int i = 1; i <= n; i++) begin
      j0 = 0;
      col_owner[0] = i;
      for (int j = 0; j < SideN; j++) begin
        slack[j]    = SlackMax;
        col_seen[j] = 1'b0;
      end
      do begin
        i0    = col_owner[j0];
        j1    = 0;
        delta = SlackMax;
        col_seen[j0] = 1'b1;
        for (int j = 1; j <= n; j++) begin
          if (!col_seen[j]) begin
            cur = row_pot[i0] + col_pot[j] - weight_at(i0, j);
            if (cur < slack[j]) begin
              slack[j] = cur;
              back[j]  = j0;
            end
            if (slack[j] < delta) begin
              delta = slack[j];
              j1    = j;
            end
          end
        end
        if (j1 == 0) break;
        for (int j = 0; j <= n; j++) begin
          if (col_seen[j]) begin
            row_pot[col_owner[j] & 31] -= delta;
            col_pot[j] += delta;
          end else begin
            slack[j] -= delta;
          end
        end
        j0 = j1;
      end while (col_owner[j0] != 0);
      while (j0 != 0) begin
        j1 = back[j0];
        if (j1 > MaxSide) j1 = 0;
        col_owner[j0] = col_owner[j1];
        j0 = j1;
      end
    end
  endtask

  task automatic predict_item(mwas_item_t it);
    int     lc, rc, n, u;
    longint total;
    lc = clamp_count(left_cnt);
    rc = clamp_count(right_cnt);
    if (it.opcode == OpAdd) begin
      if (it.row_index >= lc) begin
        queue_expected(make_result(StatusLeftOor, 0, 0, '0, 1'b1));
      end else if (it.col_index >= rc) begin
        queue_expected(make_result(StatusRightOor, 0, 0, '0, 1'b1));
      end else begin
        if (!it.edge_weight[31] &&
            it.edge_weight[30:0] > weights[it.row_index][it.col_index])
          weights[it.row_index][it.col_index] = it.edge_weight[30:0];
        queue_expected(make_result(StatusOk, 0, 0, '0, 1'b1));
      end
    end else begin
      n     = (lc > rc) ? lc : rc;
      total = 0;
      run_assignment(n);
      for (int v = 1; v <= n; v++) begin
        u = col_owner[v];
        if (u > 0 && u <= lc && v <= rc && weight_at(u, v) > 0) begin
          total += weight_at(u, v);
          queue_expected(make_result(StatusOk, u - 1, v - 1, '0, 1'b0));
        end
      end
      queue_expected(make_result(StatusOk, 0, 0, TotW'(total), 1'b1));
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic compare_result(mwas_result_t got);
    mwas_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result transaction, status", got.status, 0);
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.left_vertex !== want.left_vertex)
      report_mismatch("left_vertex", got.left_vertex, want.left_vertex);
    if (got.right_vertex !== want.right_vertex)
      report_mismatch("right_vertex", got.right_vertex, want.right_vertex);
    if (got.total_weight !== want.total_weight)
      report_mismatch("total_weight", got.total_weight, want.total_weight);
    if (got.last !== want.last) report_mismatch("last", got.last, want.last);
  endtask

  initial begin
    errors    = 0;
    left_cnt  = 5'd16;
    right_cnt = 5'd16;
    clear_weights();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegLeftCount) begin
          left_cnt = cfg_data_i;
          clear_weights();
        end else if (cfg_index_i == RegRightCount) begin
          right_cnt = cfg_data_i;
          clear_weights();
        end
      end
      if (start_i && !busy_i) predict_item(item_i);
      if (res_valid_i) compare_result(res_i);
    end
  end

endmodule

// ===== verif/max_weight_assignment_solver_top_test.sv =====
// Testbench top for the max-weight assignment solver: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module max_weight_assignment_solver_top_test
  import mwas_pkg::*;
();

  // Index with no register behind it; a write there must change nothing.
  localparam logic [1:0] RegUnmapped = 2'd2;
  localparam int         IdleLimit   = 300000;
  localparam int         ItemTarget  = 450;

  logic         clk_i;
  logic         rst_ni;
  logic         start;
  mwas_item_t   item_drv;
  logic         busy;
  logic         res_valid_o;
  mwas_result_t res_o;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [4:0]   cfg_data_i;
  int           errors;
  int           pending;
  int           items_sent;
  int           burst_left;
  int           idle_cycles;

  max_weight_assignment_solver_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .item_i      (item_drv),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  max_weight_assignment_solver_checker checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (item_drv),
    .res_valid_i (res_valid_o),
    .res_i       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run if nothing is accepted for too long. A full-size
  // solve with 16 vertices per side stays well inside the limit.
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Hold start and the item until the block takes the transaction, then
  // either stay in the burst or drop start for a random gap.
  task automatic send_item(mwas_item_t it);
    @(negedge clk_i);
    start    = 1'b1;
    item_drv = it;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    items_sent++;
    if (burst_left == 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_edge(int row, int col, logic signed [31:0] w);
    mwas_item_t it;
    it.opcode      = OpAdd;
    it.row_index   = row[5:0];
    it.col_index   = col[5:0];
    it.edge_weight = w;
    send_item(it);
  endtask

  task automatic solve_now();
    mwas_item_t it;
    it.opcode      = OpSolve;
    it.row_index   = 6'($urandom);
    it.col_index   = 6'($urandom);
    it.edge_weight = $urandom;
    send_item(it);
  endtask

  // Drop start, wait for every expected result, then let the block settle.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_counts(logic [4:0] lc, logic [4:0] rc);
    drain();
    write_reg(RegLeftCount, lc);
    write_reg(RegRightCount, rc);
  endtask

  function automatic logic signed [31:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return 32'sh7fff_ffff;
      1:       return $urandom;
      2:       return -$signed(32'($urandom_range(1, 1000)));
      default: return $urandom_range(0, 200);
    endcase
  endfunction

  // Mostly indexes inside the configured count; a few anywhere in the field.
  function automatic int pick_index(int cnt);
    if (cnt == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, cnt - 1);
  endfunction

  initial begin
    int lc, rc, lce, rce, adds;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_drv    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegLeftCount;
    cfg_data_i  = '0;
    items_sent  = 0;
    burst_left  = 0;
    idle_cycles = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset counts, weight extremes, repeated edge, both range errors.
    load_edge(0, 0, 5);
    load_edge(15, 15, 32'sh7fff_ffff);
    load_edge(0, 0, 32'sh8000_0000);
    load_edge(0, 0, 3);
    load_edge(0, 0, 9);
    load_edge(16, 0, 7);
    load_edge(0, 16, 7);
    load_edge(63, 63, -1);
    load_edge(3, 7, 0);
    solve_now();

    // Rectangular problem, then an unmapped register write between solves.
    set_counts(5'd3, 5'd5);
    load_edge(2, 4, 100);
    load_edge(0, 4, 90);
    load_edge(1, 0, 10);
    load_edge(3, 0, 1);
    load_edge(0, 5, 1);
    solve_now();
    drain();
    write_reg(RegUnmapped, 5'd7);
    solve_now();

    // Empty problem, then counts above the storage side.
    set_counts(5'd0, 5'd0);
    solve_now();
    load_edge(0, 0, 1);
    set_counts(5'd31, 5'd20);
    load_edge(15, 0, 42);
    load_edge(16, 16, 42);
    solve_now();

    // Random phases: counts, a batch of edges, a solve. Most problems stay small.
    while (items_sent < ItemTarget) begin
      case ($urandom_range(0, 19))
        0:       begin lc = 16; rc = 16; end
        1:       begin lc = $urandom_range(0, 31); rc = $urandom_range(17, 31); end
        2:       begin lc = $urandom_range(0, 6); rc = 0; end
        default: begin lc = $urandom_range(1, 6); rc = $urandom_range(1, 6); end
      endcase
      set_counts(5'(lc), 5'(rc));
      if ($urandom_range(0, 7) == 0) begin
        drain();
        write_reg(RegUnmapped + 2'($urandom_range(0, 1)), 5'($urandom));
      end
      lce  = (lc > 16) ? 16 : lc;
      rce  = (rc > 16) ? 16 : rc;
      adds = $urandom_range(1, 20);
      repeat (adds) load_edge(pick_index(lce), pick_index(rce), pick_weight());
      solve_now();
      if ($urandom_range(0, 3) == 0) solve_now();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mwas_pkg.sv
hdl/mwas_wmem.sv
hdl/mwas_core.sv
hdl/max_weight_assignment_solver_top.sv
verif/max_weight_assignment_solver_checker.sv
verif/max_weight_assignment_solver_top_test.sv
